>>> rtl/core/mtcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcv_pkg
// Shared constants for the multichannel threshold crossing velocity unit:
// register indexes, register reset values, field widths and default sizes.
// ----------------------------------------------------------------------------
package mtcv_pkg;

  // Default sizes
  localparam int CHANNELS_DEF    = 16;
  localparam int DELAY_DEPTH_DEF = 8;

  // Field widths
  localparam int CH_FIELD_W  = 4;
  localparam int POS_W       = 16;
  localparam int VEL_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_W     = 24;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_HIGH = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_GAIN  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DETECT_ENABLE  = 8'd3;

  // Register reset values
  localparam logic [POS_W-1:0]  THRESHOLD_LOW_RST  = 16'd26214;
  localparam logic [POS_W-1:0]  THRESHOLD_HIGH_RST = 16'd39321;
  localparam logic [GAIN_W-1:0] VELOCITY_GAIN_RST  = 16'd256;
  localparam logic              DETECT_ENABLE_RST  = 1'b1;

endpackage

>>> rtl/core/multichannel_threshold_crossing_velocity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_threshold_crossing_velocity_unit
// Per-channel delay-line threshold crossing detector with hold-off and a
// saturated Q1.15 crossing velocity.
// ----------------------------------------------------------------------------
//  Channel | Handshake                  | Payload
//  --------+----------------------------+---------------------------------------
//  s_      | s_tvalid / s_tready        | tdata: channel, position; tuser: high
//          |                            | threshold select; tlast: frame end
//  m_      | m_tvalid / m_tready        | tdata: channel, velocity; tuser: damp
//  cfg_    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  One item per cycle sustained while the output is not stalled; each item passes
//  through the delay/hold-off memory read, compare, multiply, round and
//  saturate into the output register.
//  After reset the delay memory is cleared, one entry a cycle, over all
//  CHANNELS * 2**clog2(DELAY_DEPTH) entries with s_tready low.
//  Each stage holds only when the stage after it is full and stalled, so
//  input transfers continue while a result waits as long as a bubble exists.
//  Back-to-back items on one channel use forwarding around the memories.
// ----------------------------------------------------------------------------
module multichannel_threshold_crossing_velocity_unit
  import mtcv_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // [3:0] channel, [19:4] position
  input  logic                   s_tuser,   // [0] use_high_threshold
  input  logic                   s_tlast,   // frame_end
  // master stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_W-1:0]     m_tdata,   // [3:0] out_channel, [19:4] velocity
  output logic                   m_tuser,   // [0] damp_event
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW        = $clog2(DELAY_DEPTH);
  localparam int MEM_DEPTH = CHANNELS << SW;
  localparam int AW        = CH_W + SW;
  localparam int HW        = $clog2(2 * DELAY_DEPTH + 1);
  localparam int PROD_W    = POS_W + 1 + GAIN_W;
  localparam logic [HW-1:0] HOLD_RELOAD = HW'(2 * DELAY_DEPTH);
  localparam logic [SW-1:0] SLOT_LAST   = SW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] ADDR_LAST   = AW'(MEM_DEPTH - 1);

  // Configuration registers
  logic [POS_W-1:0]  threshold_low;
  logic [POS_W-1:0]  threshold_high;
  logic [GAIN_W-1:0] velocity_gain;
  logic              detect_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_low  <= THRESHOLD_LOW_RST;
      threshold_high <= THRESHOLD_HIGH_RST;
      velocity_gain  <= VELOCITY_GAIN_RST;
      detect_enable  <= DETECT_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD_LOW:  threshold_low  <= cfg_data;
        REG_THRESHOLD_HIGH: threshold_high <= cfg_data;
        REG_VELOCITY_GAIN:  velocity_gain  <= cfg_data;
        REG_DETECT_ENABLE:  detect_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage control
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic clearing;
  logic s_fire, step1;

  assign en3      = !m_tvalid || m_tready;
  assign en2      = !v3 || en3;
  assign en1      = !v2 || en2;
  assign s_tready = (!v1 || en1) && !clearing;
  assign s_fire   = s_tvalid && s_tready;
  assign step1    = v1 && en1;

  // Input decode
  logic [CH_FIELD_W-1:0] s_channel;
  logic [POS_W-1:0]      s_position;
  logic [CH_W-1:0]       s_ch_idx;
  logic                  s_in_range;
  logic [SW-1:0]         delay_slot;
  logic [SW-1:0]         slot_rd;

  assign s_channel  = s_tdata[3:0];
  assign s_position = s_tdata[19:4];
  assign s_ch_idx   = CH_W'(s_channel);
  assign s_in_range = (8'(s_channel) < 8'(CHANNELS));
  assign slot_rd    = (delay_slot == SLOT_LAST) ? '0 : delay_slot + 1'b1;

  // Advance the shared slot on an enabled frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_slot <= '0;
    end else if (s_fire && detect_enable && s_tlast) begin
      delay_slot <= slot_rd;
    end
  end

  // Clearing pass over the delay memory
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Stage 1 registers (memory read in flight)
  logic [CH_FIELD_W-1:0] ch1;
  logic [CH_W-1:0]       ch_idx1;
  logic                  act1;
  logic [POS_W-1:0]      pos1;
  logic [POS_W-1:0]      th1;
  logic [AW-1:0]         wa1;

  // Write-back of stage 1
  logic            wb1;
  logic [HW-1:0]   hold_next;
  logic [AW-1:0]   dly_ra;

  assign wb1    = step1 && act1;
  assign dly_ra = {s_ch_idx, slot_rd};

  // Delay memory: one write, one registered read
  logic [POS_W-1:0] dly_mem [MEM_DEPTH];
  logic [POS_W-1:0] dly_rd;
  logic             dly_we;
  logic [AW-1:0]    dly_wa;
  logic [POS_W-1:0] dly_wd;

  assign dly_we = clearing || wb1;
  assign dly_wa = clearing ? clr_addr : wa1;
  assign dly_wd = clearing ? '0 : pos1;

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    if (s_fire) begin
      dly_rd <= dly_mem[dly_ra];
    end
  end

  // Hold-off memory with valid bits standing for the reload value
  logic [HW-1:0]       hold_mem [CHANNELS];
  logic [HW-1:0]       hold_rd;
  logic [CHANNELS-1:0] hold_vld;
  logic                hold_init1;

  always_ff @(posedge clk) begin
    if (wb1) begin
      hold_mem[ch_idx1] <= hold_next;
    end
    if (s_fire) begin
      hold_rd <= hold_mem[s_ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= '0;
    end else if (wb1) begin
      hold_vld[ch_idx1] <= 1'b1;
    end
  end

  // Capture the accepted item and forwarding hits
  logic             dfwd, hfwd;
  logic [POS_W-1:0] dfwd_data;
  logic [HW-1:0]    hfwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!v1 || en1) begin
      v1 <= s_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      ch1        <= s_channel;
      ch_idx1    <= s_ch_idx;
      act1       <= detect_enable && s_in_range;
      pos1       <= s_position;
      th1        <= s_tuser ? threshold_high : threshold_low;
      wa1        <= {s_ch_idx, delay_slot};
      hold_init1 <= !hold_vld[s_ch_idx];
      dfwd       <= wb1 && (wa1 == dly_ra);
      hfwd       <= wb1 && (ch_idx1 == s_ch_idx);
      dfwd_data  <= pos1;
      hfwd_data  <= hold_next;
    end
  end

  // Stage 1: compare against the oldest sample and update hold-off
  logic [POS_W-1:0]   old1;
  logic [HW-1:0]      hold_cur;
  logic               rise1, fall1, cross1;
  logic signed [POS_W:0] diff1;

  always_comb begin
    old1     = dfwd ? dfwd_data : dly_rd;
    hold_cur = hfwd ? hfwd_data : (hold_init1 ? HOLD_RELOAD : hold_rd);
    rise1    = (pos1 >= th1) && (old1 < th1);
    fall1    = (pos1 <= th1) && (old1 > th1);
    cross1   = 1'b0;
    if (hold_cur == '0) begin
      cross1    = rise1 || fall1;
      hold_next = cross1 ? HOLD_RELOAD : '0;
    end else begin
      hold_next = hold_cur - 1'b1;
    end
    diff1 = $signed({1'b0, pos1}) - $signed({1'b0, old1});
  end

  // Stage 2: difference and event flags
  logic [CH_FIELD_W-1:0] ch2;
  logic                  cross2, fall2;
  logic signed [POS_W:0] diff2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en1) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (step1) begin
      ch2    <= ch1;
      cross2 <= act1 && cross1;
      fall2  <= act1 && cross1 && !rise1;
      diff2  <= diff1;
    end
  end

  // Stage 3: product with the gain
  logic [CH_FIELD_W-1:0]     ch3;
  logic                      cross3, fall3;
  logic signed [PROD_W-1:0]  prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en2) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && en2) begin
      ch3    <= ch2;
      cross3 <= cross2;
      fall3  <= fall2;
      prod3  <= PROD_W'(diff2) * PROD_W'($signed({1'b0, velocity_gain}));
    end
  end

  // Round to nearest (ties up) by 2**9, then saturate to Q1.15
  logic signed [PROD_W:0]      rnd_sum;
  logic signed [PROD_W-9:0]    rnd_q;
  logic [VEL_W-1:0]            vel_sat;

  always_comb begin
    rnd_sum = $signed({prod3[PROD_W-1], prod3}) + $signed((PROD_W+1)'(256));
    rnd_q   = rnd_sum[PROD_W:9];
    if (!rnd_q[PROD_W-9] && (|rnd_q[PROD_W-10:VEL_W-1])) begin
      vel_sat = 16'h7FFF;
    end else if (rnd_q[PROD_W-9] && !(&rnd_q[PROD_W-10:VEL_W-1])) begin
      vel_sat = 16'h8000;
    end else begin
      vel_sat = rnd_q[VEL_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en3) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && en3) begin
      m_tdata <= {4'b0, (cross3 ? vel_sat : {VEL_W{1'b0}}), ch3};
      m_tuser <= fall3;
    end
  end

`ifndef ASSERT_OFF
  // No item may be in flight while the delay memory is being cleared
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(v1 || v2 || v3 || m_tvalid))
    else $error("item in flight during clearing pass");

  // Hold-off write-back never exceeds the reload value
  assert property (@(posedge clk) disable iff (rst)
    wb1 |-> (hold_next <= HOLD_RELOAD))
    else $error("hold-off count above reload");

  // A damp event carries a velocity that is not positive
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[19] || (m_tdata[19:4] == 16'h0000)))
    else $error("damp event with positive velocity");

  // A result arriving in the output register comes from stage 3
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v3))
    else $error("result without a stage 3 item");
`endif

endmodule

>>> tb/mtcv_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcv_result_checker
// Passive checker for the threshold crossing velocity unit. It follows every
// register write and every input transfer, and keeps its own copy of the
// delay lines, hold-off counters and shared slot. From these it works out the
// result of each sample. Each output transfer is compared field by field with
// the oldest result still owed. The failure count and the number of results
// still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module mtcv_result_checker
  import mtcv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // [3:0] channel, [19:4] position
  input  logic                   s_tuser,   // [0] use_high_threshold
  input  logic                   s_tlast,   // frame_end
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [TDATA_W-1:0]     m_tdata,   // [3:0] out_channel, [19:4] velocity
  input  logic                   m_tuser,   // [0] damp_event
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     owed_results
);

  localparam int          DEPTH          = DELAY_DEPTH_DEF;
  localparam logic [4:0]  HOLDOFF_RELOAD = 5'(2 * DELAY_DEPTH_DEF);

  typedef struct packed {
    logic [CH_FIELD_W-1:0]   channel;
    logic                    damp;
    logic signed [VEL_W-1:0] velocity;
  } crossing_result_t;

  crossing_result_t expected_results[$];

  // Shadow registers and channel state
  logic [POS_W-1:0]  thr_low;
  logic [POS_W-1:0]  thr_high;
  logic [GAIN_W-1:0] gain_q88;
  logic              detect_on;
  logic [POS_W-1:0]  history [CHANNELS_DEF][DEPTH];
  logic [4:0]        holdoff_left [CHANNELS_DEF];
  int unsigned       slot;

  // Q0.16 difference times Q8.8 gain, rounded to Q1.15 and saturated
  function automatic logic signed [VEL_W-1:0] crossing_speed(logic [POS_W-1:0] now,
                                                            logic [POS_W-1:0] old);
    longint diff;
    longint prod;
    longint vel;
    diff = longint'(now) - longint'(old);
    prod = diff * longint'(gain_q88);
    vel  = (prod + 256) >>> 9;
    if (vel > 32767)  vel = 32767;
    if (vel < -32768) vel = -32768;
    return vel[VEL_W-1:0];
  endfunction

  task automatic clear_state();
    thr_low   = THRESHOLD_LOW_RST;
    thr_high  = THRESHOLD_HIGH_RST;
    gain_q88  = VELOCITY_GAIN_RST;
    detect_on = DETECT_ENABLE_RST;
    slot      = 0;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      holdoff_left[c] = HOLDOFF_RELOAD;
      for (int k = 0; k < DEPTH; k++) history[c][k] = '0;
    end
    expected_results.delete();
  endtask

  task automatic apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_THRESHOLD_LOW:  thr_low   = val;
      REG_THRESHOLD_HIGH: thr_high  = val;
      REG_VELOCITY_GAIN:  gain_q88  = val;
      REG_DETECT_ENABLE:  detect_on = val[0];
      default: ;
    endcase
  endtask

  // Work out the result of one sample and advance the shadow state
  task automatic predict_sample(logic [CH_FIELD_W-1:0] ch, logic [POS_W-1:0] now,
                                logic use_high, logic frame_end);
    crossing_result_t res;
    logic [POS_W-1:0] th;
    logic [POS_W-1:0] old;
    res.channel  = ch;
    res.damp     = 1'b0;
    res.velocity = '0;
    th = use_high ? thr_high : thr_low;
    if (detect_on) begin
      old = history[ch][(slot + 1) % DEPTH];
      history[ch][slot] = now;
      if (holdoff_left[ch] == 0) begin
        if (now >= th && old < th) begin
          res.velocity     = crossing_speed(now, old);
          holdoff_left[ch] = HOLDOFF_RELOAD;
        end else if (now <= th && old > th) begin
          res.damp         = 1'b1;
          res.velocity     = crossing_speed(now, old);
          holdoff_left[ch] = HOLDOFF_RELOAD;
        end
      end else begin
        holdoff_left[ch] = holdoff_left[ch] - 1'b1;
      end
      if (frame_end) slot = (slot + 1) % DEPTH;
    end
    expected_results.push_back(res);
  endtask

  task automatic check_result();
    crossing_result_t exp_res;
    logic signed [VEL_W-1:0] got_vel;
    got_vel = m_tdata[19:4];
    if (expected_results.size() == 0) begin
      $error("result with nothing owed: channel %0d velocity %0d damp %0b",
             m_tdata[3:0], got_vel, m_tuser);
      fail_count++;
    end else begin
      exp_res = expected_results.pop_front();
      if (m_tdata[3:0] !== exp_res.channel) begin
        $error("out_channel: expected %0d, got %0d", exp_res.channel, m_tdata[3:0]);
        fail_count++;
      end
      if (m_tuser !== exp_res.damp) begin
        $error("damp_event: expected %0b, got %0b", exp_res.damp, m_tuser);
        fail_count++;
      end
      if (got_vel !== exp_res.velocity) begin
        $error("crossing_velocity: expected %0d, got %0d", exp_res.velocity, got_vel);
        fail_count++;
      end
    end
  endtask

  // Follow the three channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predict_sample(s_tdata[3:0], s_tdata[19:4], s_tuser, s_tlast);
      if (m_tvalid && m_tready) check_result();
    end
    owed_results = expected_results.size();
  end

endmodule

>>> tb/tb_multichannel_threshold_crossing_velocity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_threshold_crossing_velocity_unit
// Drives position samples into the crossing velocity unit across several
// register settings: the reset values, threshold and gain extremes, a disabled
// stretch and random settings. Samples come mostly as frames over a few busy
// channels, whose levels swing across the thresholds so that hold-off runs
// out and crossings occur. Some random samples are mixed in. Both stream sides
// idle at random. All checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_multichannel_threshold_crossing_velocity_unit;
  import mtcv_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 16;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [TDATA_W-1:0]     m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_count   = 0;
  bit          source_gaps   = 1'b0;
  bit          sink_stalls   = 1'b0;
  bit          long_hold_req = 1'b0;

  // Thresholds as last written, used to aim positions around them
  logic [POS_W-1:0]      thr_low_now  = THRESHOLD_LOW_RST;
  logic [POS_W-1:0]      thr_high_now = THRESHOLD_HIGH_RST;
  bit                    level_high [CHANNELS_DEF];
  logic [CH_FIELD_W-1:0] busy_ch [3];

  always #5 clk = ~clk;

  multichannel_threshold_crossing_velocity_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mtcv_result_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (mismatches),
    .owed_results (outstanding)
  );

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Offer one sample and hold it until the transfer; valid stays high after
  task automatic send_sample(logic [CH_FIELD_W-1:0] ch, logic [POS_W-1:0] pos,
                             logic use_high, logic frame_end);
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, pos, ch};
    s_tuser  <= use_high;
    s_tlast  <= frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Offer one register write; valid is left high for the caller to drop
  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_THRESHOLD_LOW:  thr_low_now  = val;
      REG_THRESHOLD_HIGH: thr_high_now = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                logic [GAIN_W-1:0] gain, logic [CFG_DATA_W-1:0] en_word);
    write_register(REG_THRESHOLD_LOW, lo);
    write_register(REG_THRESHOLD_HIGH, hi);
    write_register(REG_VELOCITY_GAIN, gain);
    write_register(REG_DETECT_ENABLE, en_word);
    cfg_valid <= 1'b0;
  endtask

  // Position above or below a threshold, sometimes exactly on it
  function automatic logic [POS_W-1:0] pick_position(bit above, logic [POS_W-1:0] th);
    if ($urandom_range(0, 7) == 0) return th;
    if (above) return 16'($urandom_range(65535, th));
    return 16'($urandom_range(th, 0));
  endfunction

  // Frames over a few busy channels, with random stray samples mixed in
  task automatic run_phase(int n_items);
    int                    sent;
    int                    last_k;
    bit                    present [3];
    bit                    use_high;
    logic [CH_FIELD_W-1:0] ch;
    logic [POS_W-1:0]      th;
    sent = 0;
    for (int k = 0; k < 3; k++) busy_ch[k] = 4'($urandom_range(0, 15));
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_sample(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          busy_ch[$urandom_range(0, 2)] = 4'($urandom_range(0, 15));
        end
        last_k = -1;
        for (int k = 0; k < 3; k++) begin
          present[k] = ($urandom_range(0, 4) != 0);
          if (present[k]) last_k = k;
        end
        if (last_k < 0) begin
          present[2] = 1'b1;
          last_k     = 2;
        end
        for (int k = 0; k <= last_k; k++) begin
          if (present[k]) begin
            ch = busy_ch[k];
            if ($urandom_range(0, 7) == 0) level_high[ch] = !level_high[ch];
            use_high = 1'($urandom_range(0, 1));
            th = use_high ? thr_high_now : thr_low_now;
            send_sample(ch, pick_position(level_high[ch], th), use_high, k == last_k);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;

    // Field extremes under the reset settings; every channel is still in hold-off
    send_sample(4'd0, 16'h0000, 1'b0, 1'b0);
    send_sample(4'd15, 16'hFFFF, 1'b1, 1'b1);
    send_sample(4'd10, 16'hAAAA, 1'b0, 1'b0);
    send_sample(4'd5, 16'h5555, 1'b1, 1'b1);
    // One channel alone, one sample per frame: hold-off runs out on the last,
    // which rises from zero to full scale and saturates the velocity
    for (int k = 0; k < 17; k++) send_sample(4'd1, (k < 10) ? 16'h0000 : 16'hFFFF, 1'b0, 1'b1);
    wait_drained();

    run_phase(270);
    wait_drained();

    // Extreme thresholds and gain; hold the result side while samples keep coming
    apply_settings(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001);
    long_hold_req = 1'b1;
    run_phase(270);
    wait_drained();

    // Smallest non-zero gain; pause the sender half way until all results are in
    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'h0001, 16'h0001);
    run_phase(130);
    wait_drained();
    run_phase(130);
    wait_drained();

    // Disabled by a wide write whose low bit is clear; stray indexes are ignored
    write_register(8'd4, 16'h1234);
    write_register(8'hFF, 16'hFFFF);
    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'hFFFE);
    run_phase(200);
    wait_drained();

    // Re-enabled with zero gain and thresholds in the middle
    apply_settings(16'h8000, 16'h8000, 16'h0000, 16'h0003);
    run_phase(270);
    wait_drained();

    // Closing stretch at full rate on both sides
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'h0001);
    run_phase(300);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
